>>> hw/rtl/fft2d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fft2d_pkg
// Shared types, constants, the twiddle table and saturation helpers for the
// square 2D radix-2 image FFT.
// ----------------------------------------------------------------------------
package fft2d_pkg;

  // Geometry and number formats.
  localparam int MAX_LG     = 6;
  localparam int LG_W       = 3;
  localparam int SAMPLE_W   = 24;
  localparam int TW_W       = 16;
  localparam int TW_FRAC    = TW_W - 2;
  localparam int IDX_W      = 14;
  localparam int STORE_DEPTH = 3 << (2 * MAX_LG);
  localparam int POS_W      = 2 * MAX_LG;
  localparam int TW_AW      = MAX_LG + 2;
  localparam int TW_ROM_SIZE = 1 << TW_AW;

  // Butterfly datapath widths.
  localparam int PROD_W = TW_W + 1 + SAMPLE_W;
  localparam int TR_W   = PROD_W + 1 - TW_FRAC;
  localparam int SUM_W  = TR_W + 1;

  // Operation codes.
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_XFORM = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_SAT   = 2'd2;

  // Register map.
  localparam logic REG_LOG2_SIDE     = 1'b0;
  localparam logic REG_THREE_CHANNEL = 1'b1;

  typedef struct packed {
    logic [1:0]                 op;
    logic [IDX_W-1:0]           elem_index;
    logic signed [SAMPLE_W-1:0] re_in;
    logic signed [SAMPLE_W-1:0] im_in;
    logic                       inverse_dir;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] re_out;
    logic signed [SAMPLE_W-1:0] im_out;
    logic [1:0]                 status;
  } out_item_t;

  // Source of the data written into the sample store.
  typedef enum logic [2:0] {
    WS_HOST,
    WS_PSWAP,
    WS_QSWAP,
    WS_SUM,
    WS_DIF,
    WS_SCALE
  } wsel_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    wsel_e             wr_sel;
    logic              cap_a;
    logic              mul_en;
    logic [TW_AW-1:0]  tw_addr;
    logic              inv;
    logic [LG_W-1:0]   lg;
    logic              sat_clr;
    logic              out_load;
    logic              out_ram;
    logic              out_range;
    logic              out_sat;
  } dp_cmd_t;

  typedef logic [TW_ROM_SIZE-1:0][2*TW_W-1:0] tw_rom_t;

  localparam longint PI_Q32 = 64'sd13493037705;

  // Quotient of two non-negative numbers by shift and subtract; used only
  // while the twiddle table is built.
  function automatic longint udiv_f(input longint n, input longint d);
    longint q;
    longint r;
    q = 0;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      r = (r << 1) | ((n >>> b) & 64'sd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'sd1 << b);
      end
    end
    return q;
  endfunction

  // Cosine and sine of pi*r/2^(MAX_LG+2) in twiddle format, from a Taylor
  // series in Q30. Packed as {cos, sin}.
  function automatic logic [2*TW_W-1:0] tw_oct_f(input longint r);
    longint x;
    longint x2;
    longint tc;
    longint ts;
    longint ac;
    longint as_v;
    longint cq;
    longint sq;
    x  = (PI_Q32 * r + (64'sd1 << (MAX_LG + 3))) >>> (MAX_LG + 4);
    x2 = (x * x + (64'sd1 << 29)) >>> 30;
    tc = 64'sd1 << 30;
    ts = x;
    ac = tc;
    as_v = ts;
    for (int i = 1; i <= 8; i++) begin
      tc = udiv_f((tc * x2) >>> 30, longint'((2 * i - 1) * (2 * i)));
      ts = udiv_f((ts * x2) >>> 30, longint'((2 * i) * (2 * i + 1)));
      if ((i & 1) == 1) begin
        ac = ac - tc;
        as_v = as_v - ts;
      end else begin
        ac = ac + tc;
        as_v = as_v + ts;
      end
    end
    if (ac < 0) ac = 0;
    if (as_v < 0) as_v = 0;
    cq = (ac + (64'sd1 << (29 - TW_FRAC))) >>> (30 - TW_FRAC);
    sq = (as_v + (64'sd1 << (29 - TW_FRAC))) >>> (30 - TW_FRAC);
    return {TW_W'(cq), TW_W'(sq)};
  endfunction

  // Whole twiddle table over half a turn, built from the first octant.
  function automatic tw_rom_t tw_rom_f();
    tw_rom_t rom;
    logic [2*TW_W-1:0] cs;
    logic [TW_W-1:0] c;
    logic [TW_W-1:0] s;
    longint o;
    o = longint'(1) << MAX_LG;
    for (int a = 0; a < TW_ROM_SIZE; a++) begin
      if (a <= o) begin
        cs = tw_oct_f(a);
        c = cs[2*TW_W-1:TW_W];
        s = cs[TW_W-1:0];
        rom[a] = {c, s};
      end else if (a <= 2 * o) begin
        cs = tw_oct_f(2 * o - a);
        c = cs[2*TW_W-1:TW_W];
        s = cs[TW_W-1:0];
        rom[a] = {s, c};
      end else if (a <= 3 * o) begin
        cs = tw_oct_f(a - 2 * o);
        c = cs[2*TW_W-1:TW_W];
        s = cs[TW_W-1:0];
        rom[a] = {TW_W'(-s), c};
      end else begin
        cs = tw_oct_f(4 * o - a);
        c = cs[2*TW_W-1:TW_W];
        s = cs[TW_W-1:0];
        rom[a] = {TW_W'(-c), s};
      end
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = tw_rom_f();

  // True when a butterfly sum does not fit the sample width.
  function automatic logic sat_ovf_f(input logic signed [SUM_W-1:0] v);
    return !((&v[SUM_W-1:SAMPLE_W-1]) || (~|v[SUM_W-1:SAMPLE_W-1]));
  endfunction

  // Saturate a butterfly sum to the sample width.
  function automatic logic [SAMPLE_W-1:0] sat_f(input logic signed [SUM_W-1:0] v);
    logic [SAMPLE_W-1:0] r;
    if (sat_ovf_f(v)) begin
      r = v[SUM_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fft2d_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fft2d_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module fft2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/fft2d_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fft2d_ctrl
// Controller: handles both item channels and sequences the permutation,
// butterfly passes and final scaling by issuing datapath commands.
// ----------------------------------------------------------------------------
module fft2d_ctrl (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire fft2d_pkg::in_item_t            in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  input  wire logic [fft2d_pkg::LG_W-1:0]     log2_side_i,
  input  wire logic                           three_channel_i,
  output fft2d_pkg::dp_cmd_t                  cmd_o
);

  localparam int LW  = fft2d_pkg::MAX_LG;
  localparam int PW  = fft2d_pkg::POS_W;
  localparam int BW  = LW - 1;
  localparam int IW  = fft2d_pkg::IDX_W;
  localparam int GW  = fft2d_pkg::LG_W;
  localparam int TAW = fft2d_pkg::TW_AW;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_RDWAIT = 4'd1;
  localparam logic [3:0] ST_PCHK   = 4'd2;
  localparam logic [3:0] ST_PRDA   = 4'd3;
  localparam logic [3:0] ST_PRDB   = 4'd4;
  localparam logic [3:0] ST_PWRA   = 4'd5;
  localparam logic [3:0] ST_PWRB   = 4'd6;
  localparam logic [3:0] ST_BRDA   = 4'd7;
  localparam logic [3:0] ST_BRDB   = 4'd8;
  localparam logic [3:0] ST_BMUL   = 4'd9;
  localparam logic [3:0] ST_BWRA   = 4'd10;
  localparam logic [3:0] ST_BWRB   = 4'd11;
  localparam logic [3:0] ST_SRD    = 4'd12;
  localparam logic [3:0] ST_SWR    = 4'd13;
  localparam logic [3:0] ST_DONE   = 4'd14;

  logic [3:0]    state_q, state_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [1:0]    k_q, k_d;
  logic          pass_q, pass_d;
  logic [LW-1:0] line_q, line_d;
  logic [GW-1:0] stg_q, stg_d;
  logic [BW-1:0] bf_q, bf_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic          inv_q, inv_d;
  logic          out_valid_q, out_valid_d;

  logic [GW-1:0] lg;
  logic [LW:0]   side;
  logic [LW-1:0] side_m1;
  logic [BW-1:0] half_m1;
  logic [PW:0]   cells;
  logic [IW:0]   area;
  logic          in_range;
  logic          out_free;
  logic          accept;
  logic          pos_last, chn_last, line_last, stg_last, bf_last, cnt_last;
  logic [LW-1:0] prow, pcol;
  logic [PW-1:0] qpos;
  logic [BW-1:0] bmask, bj;
  logic [LW-1:0] bi, biq;
  logic [PW-1:0] bpos_a, bpos_b;
  logic [IW-1:0] perm_pa, perm_qa, bf_pa, bf_qa;

  // Flat store address of a sample position and channel.
  function automatic logic [IW-1:0] flat_f(input logic [PW-1:0] p, input logic [1:0] kk,
                                           input logic c3);
    return c3 ? (IW'({p, 1'b0}) + IW'(p) + IW'(kk)) : IW'(p);
  endfunction

  // Bit reversal over the active side width.
  function automatic logic [LW-1:0] brev_f(input logic [LW-1:0] v, input logic [GW-1:0] l);
    logic [LW-1:0] r;
    for (int i = 0; i < LW; i++) begin
      r[LW-1-i] = v[i];
    end
    return r >> (LW - int'(l));
  endfunction

  // Effective side: zero acts as one, large values clamp to the maximum.
  always_comb begin
    if (log2_side_i == '0) begin
      lg = GW'(1);
    end else if (log2_side_i > GW'(LW)) begin
      lg = GW'(LW);
    end else begin
      lg = log2_side_i;
    end
  end

  assign side    = (LW+1)'(1) << lg;
  assign side_m1 = LW'(side - (LW+1)'(1));
  assign half_m1 = BW'((side >> 1) - (LW+1)'(1));
  assign cells   = (PW+1)'(1) << (2 * int'(lg));
  assign area    = three_channel_i ? ((IW+1)'({cells, 1'b0}) + (IW+1)'(cells))
                                   : (IW+1)'(cells);
  assign in_range = {1'b0, in_item_i.elem_index} < area;

  assign pos_last  = pos_q == PW'(cells - (PW+1)'(1));
  assign chn_last  = !three_channel_i || (k_q == 2'd2);
  assign line_last = line_q == side_m1;
  assign stg_last  = stg_q == GW'(lg - GW'(1));
  assign bf_last   = bf_q == half_m1;
  assign cnt_last  = cnt_q == IW'(area - (IW+1)'(1));

  // Permutation partner of the current position.
  assign prow    = LW'(pos_q >> lg);
  assign pcol    = LW'(pos_q) & side_m1;
  assign qpos    = (PW'(brev_f(prow, lg)) << lg) | PW'(brev_f(pcol, lg));
  assign perm_pa = flat_f(pos_q, k_q, three_channel_i);
  assign perm_qa = flat_f(qpos, k_q, three_channel_i);

  // Butterfly pair and twiddle index for the current stage.
  assign bmask  = BW'(((BW+1)'(1) << stg_q) - (BW+1)'(1));
  assign bj     = bf_q & bmask;
  assign bi     = (LW'(bf_q >> stg_q) << (int'(stg_q) + 1)) | LW'(bj);
  assign biq    = bi | (LW'(1) << stg_q);
  assign bpos_a = pass_q ? ((PW'(line_q) << lg) | PW'(bi)) : ((PW'(bi) << lg) | PW'(line_q));
  assign bpos_b = pass_q ? ((PW'(line_q) << lg) | PW'(biq)) : ((PW'(biq) << lg) | PW'(line_q));
  assign bf_pa  = flat_f(bpos_a, k_q, three_channel_i);
  assign bf_qa  = flat_f(bpos_b, k_q, three_channel_i);

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  // Next state, counters and datapath commands.
  always_comb begin
    state_d  = state_q;
    pos_d    = pos_q;
    k_d      = k_q;
    pass_d   = pass_q;
    line_d   = line_q;
    stg_d    = stg_q;
    bf_d     = bf_q;
    cnt_d    = cnt_q;
    inv_d    = inv_q;
    out_valid_d = out_valid_q && !out_ready_i;

    cmd_o          = '0;
    cmd_o.wr_sel   = fft2d_pkg::WS_HOST;
    cmd_o.tw_addr  = TAW'(TAW'(bj) << (TAW - int'(stg_q)));
    cmd_o.inv      = inv_q;
    cmd_o.lg       = lg;
    cmd_o.rd_addr  = in_item_i.elem_index;
    cmd_o.wr_addr  = in_item_i.elem_index;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_item_i.op)
            fft2d_pkg::OP_WRITE: begin
              cmd_o.wr_en     = in_range;
              cmd_o.out_load  = 1'b1;
              cmd_o.out_range = !in_range;
              out_valid_d     = 1'b1;
            end
            fft2d_pkg::OP_XFORM: begin
              cmd_o.sat_clr = 1'b1;
              inv_d   = in_item_i.inverse_dir;
              pos_d   = '0;
              k_d     = '0;
              state_d = ST_PCHK;
            end
            fft2d_pkg::OP_READ: begin
              if (in_range) begin
                cmd_o.rd_en = 1'b1;
                state_d     = ST_RDWAIT;
              end else begin
                cmd_o.out_load  = 1'b1;
                cmd_o.out_range = 1'b1;
                out_valid_d     = 1'b1;
              end
            end
            default: begin
              cmd_o.out_load = 1'b1;
              out_valid_d    = 1'b1;
            end
          endcase
        end
      end
      ST_RDWAIT: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_ram  = 1'b1;
        cmd_o.out_sat  = 1'b1;
        out_valid_d    = 1'b1;
        state_d        = ST_IDLE;
      end
      // Bit-reversal permutation: swap each pair once.
      ST_PCHK: begin
        if (pos_q < qpos) begin
          state_d = ST_PRDA;
        end else if (pos_last) begin
          pass_d = 1'b0; line_d = '0; stg_d = '0; bf_d = '0; k_d = '0;
          state_d = ST_BRDA;
        end else begin
          pos_d = pos_q + PW'(1);
        end
      end
      ST_PRDA: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = perm_pa;
        state_d       = ST_PRDB;
      end
      ST_PRDB: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = perm_qa;
        cmd_o.cap_a   = 1'b1;
        state_d       = ST_PWRA;
      end
      ST_PWRA: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = perm_pa;
        cmd_o.wr_sel  = fft2d_pkg::WS_PSWAP;
        state_d       = ST_PWRB;
      end
      ST_PWRB: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = perm_qa;
        cmd_o.wr_sel  = fft2d_pkg::WS_QSWAP;
        if (!chn_last) begin
          k_d     = k_q + 2'd1;
          state_d = ST_PRDA;
        end else begin
          k_d = '0;
          if (pos_last) begin
            pass_d = 1'b0; line_d = '0; stg_d = '0; bf_d = '0;
            state_d = ST_BRDA;
          end else begin
            pos_d   = pos_q + PW'(1);
            state_d = ST_PCHK;
          end
        end
      end
      // Butterflies: column pass, then row pass.
      ST_BRDA: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = bf_pa;
        state_d       = ST_BRDB;
      end
      ST_BRDB: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = bf_qa;
        cmd_o.cap_a   = 1'b1;
        state_d       = ST_BMUL;
      end
      ST_BMUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_BWRA;
      end
      ST_BWRA: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = bf_pa;
        cmd_o.wr_sel  = fft2d_pkg::WS_SUM;
        state_d       = ST_BWRB;
      end
      ST_BWRB: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = bf_qa;
        cmd_o.wr_sel  = fft2d_pkg::WS_DIF;
        state_d       = ST_BRDA;
        if (!bf_last) begin
          bf_d = bf_q + BW'(1);
        end else begin
          bf_d = '0;
          if (!stg_last) begin
            stg_d = stg_q + GW'(1);
          end else begin
            stg_d = '0;
            if (!chn_last) begin
              k_d = k_q + 2'd1;
            end else begin
              k_d = '0;
              if (!line_last) begin
                line_d = line_q + LW'(1);
              end else begin
                line_d = '0;
                if (!pass_q) begin
                  pass_d = 1'b1;
                end else begin
                  cnt_d   = '0;
                  state_d = ST_SRD;
                end
              end
            end
          end
        end
      end
      // Final scaling by one over the side length.
      ST_SRD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = cnt_q;
        state_d       = ST_SWR;
      end
      ST_SWR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = cnt_q;
        cmd_o.wr_sel  = fft2d_pkg::WS_SCALE;
        if (cnt_last) begin
          state_d = ST_DONE;
        end else begin
          cnt_d   = cnt_q + IW'(1);
          state_d = ST_SRD;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sat  = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      k_q         <= '0;
      pass_q      <= 1'b0;
      line_q      <= '0;
      stg_q       <= '0;
      bf_q        <= '0;
      cnt_q       <= '0;
      inv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      k_q         <= k_d;
      pass_q      <= pass_d;
      line_q      <= line_d;
      stg_q       <= stg_d;
      bf_q        <= bf_d;
      cnt_q       <= cnt_d;
      inv_q       <= inv_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/fft2d_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fft2d_dp
// Datapath: sample store, twiddle table, butterfly multiplier and adders,
// scaling shifter, saturation flag and the result register.
// ----------------------------------------------------------------------------
module fft2d_dp (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire fft2d_pkg::dp_cmd_t    cmd_i,
  input  wire fft2d_pkg::in_item_t   in_item_i,
  output fft2d_pkg::out_item_t       out_item_o
);

  localparam int SW  = fft2d_pkg::SAMPLE_W;
  localparam int TW  = fft2d_pkg::TW_W;
  localparam int PRW = fft2d_pkg::PROD_W;
  localparam int TRW = fft2d_pkg::TR_W;
  localparam int SMW = fft2d_pkg::SUM_W;
  localparam int TF  = fft2d_pkg::TW_FRAC;

  logic [2*SW-1:0]         rdata, wdata;
  logic signed [SW-1:0]    rd_re, rd_im;
  logic [2*SW-1:0]         a_q;
  logic signed [SW-1:0]    a_re, a_im;
  logic [2*TW-1:0]         tw;
  logic signed [TW:0]      wc, ws, sin_x;
  logic signed [PRW-1:0]   p_rr_q, p_ri_q, p_ir_q, p_is_q;
  logic signed [PRW:0]     tr_full, ti_full;
  logic signed [TRW-1:0]   tr, ti;
  logic signed [SMW-1:0]   s_re, s_im, d_re, d_im;
  logic signed [SW-1:0]    sc_re, sc_im;
  logic                    sat_q, sat_d;
  logic                    bf_ovf;
  fft2d_pkg::out_item_t    out_q;

  // Sample store: real part in the upper half, imaginary in the lower.
  fft2d_ram #(
    .WIDTH (2 * SW),
    .DEPTH (fft2d_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (cmd_i.wr_addr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.rd_addr),
    .rdata_o (rdata)
  );

  assign rd_re = rdata[2*SW-1:SW];
  assign rd_im = rdata[SW-1:0];
  assign a_re  = a_q[2*SW-1:SW];
  assign a_im  = a_q[SW-1:0];

  // First operand of a swap or butterfly.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_a) begin
      a_q <= rdata;
    end
  end

  // Twiddle lookup; the forward transform negates the sine.
  assign tw    = fft2d_pkg::TW_ROM[cmd_i.tw_addr];
  assign wc    = (TW+1)'($signed(tw[2*TW-1:TW]));
  assign sin_x = (TW+1)'($signed(tw[TW-1:0]));
  assign ws    = cmd_i.inv ? sin_x : -sin_x;

  // Complex multiply by the twiddle, registered products.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_rr_q <= wc * rd_re;
      p_ri_q <= ws * rd_im;
      p_ir_q <= wc * rd_im;
      p_is_q <= ws * rd_re;
    end
  end

  // Round and floor-shift the products, then add and subtract.
  assign tr_full = (PRW+1)'(p_rr_q) - (PRW+1)'(p_ri_q) + (PRW+1)'(1 <<< (TF - 1));
  assign ti_full = (PRW+1)'(p_ir_q) + (PRW+1)'(p_is_q) + (PRW+1)'(1 <<< (TF - 1));
  assign tr      = tr_full[PRW:TF];
  assign ti      = ti_full[PRW:TF];
  assign s_re    = SMW'(a_re) + SMW'(tr);
  assign s_im    = SMW'(a_im) + SMW'(ti);
  assign d_re    = SMW'(a_re) - SMW'(tr);
  assign d_im    = SMW'(a_im) - SMW'(ti);

  // Scaling by one over the side length.
  assign sc_re = rd_re >>> cmd_i.lg;
  assign sc_im = rd_im >>> cmd_i.lg;

  // Store write data.
  always_comb begin
    bf_ovf = 1'b0;
    case (cmd_i.wr_sel)
      fft2d_pkg::WS_HOST:  wdata = {in_item_i.re_in, in_item_i.im_in};
      fft2d_pkg::WS_PSWAP: wdata = rdata;
      fft2d_pkg::WS_QSWAP: wdata = a_q;
      fft2d_pkg::WS_SUM: begin
        wdata  = {fft2d_pkg::sat_f(s_re), fft2d_pkg::sat_f(s_im)};
        bf_ovf = fft2d_pkg::sat_ovf_f(s_re) || fft2d_pkg::sat_ovf_f(s_im);
      end
      fft2d_pkg::WS_DIF: begin
        wdata  = {fft2d_pkg::sat_f(d_re), fft2d_pkg::sat_f(d_im)};
        bf_ovf = fft2d_pkg::sat_ovf_f(d_re) || fft2d_pkg::sat_ovf_f(d_im);
      end
      fft2d_pkg::WS_SCALE: wdata = {sc_re, sc_im};
      default:             wdata = rdata;
    endcase
  end

  // Saturation seen during the last transform.
  assign sat_d = cmd_i.sat_clr ? 1'b0 : (sat_q || (cmd_i.wr_en && bf_ovf));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else begin
      sat_q <= sat_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.re_out <= cmd_i.out_ram ? rd_re : '0;
      out_q.im_out <= cmd_i.out_ram ? rd_im : '0;
      if (cmd_i.out_range) begin
        out_q.status <= fft2d_pkg::STAT_RANGE;
      end else if (cmd_i.out_sat && sat_q) begin
        out_q.status <= fft2d_pkg::STAT_SAT;
      end else begin
        out_q.status <= fft2d_pkg::STAT_OK;
      end
    end
  end

  assign out_item_o = out_q;

endmodule
`default_nettype wire

>>> hw/rtl/fft2d_radix2_image_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fft2d_radix2_image_top
// In-place square 2D radix-2 FFT over a store of complex image samples.
// ----------------------------------------------------------------------------
// Usage: items arrive on in_valid_i/in_ready_o, each with one result item on
// out_valid_o/out_ready_i. A write item stores its sample if the index is in
// range; its result shows in the next cycle. An in-range read item passes the
// registered store read port, then the result register. Writes stream at one
// item per cycle while the receiver takes each result. A transform item runs
// from the single store port pair: the permutation checks each position and
// reads, then writes back swapped, each channel sample pair; each butterfly
// reads, multiplies and writes (2 passes * side * channels * log2(side) *
// side/2 butterflies); scaling rewrites each element, then the result loads.
// The APB port sets log2_side (address 0) and three_channel (address 4).
// Reset restores log2_side = 6, one channel and a clear saturation flag;
// the store contents are undefined until written.
// While the receiver stalls, the result stays in the output register and
// no new item is taken until it leaves.
// ----------------------------------------------------------------------------
module fft2d_radix2_image_top (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire fft2d_pkg::in_item_t    in_item_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output fft2d_pkg::out_item_t        out_item_o,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [fft2d_pkg::LG_W-1:0] log2_side_q;
  logic                       three_channel_q;
  logic                       cfg_we;
  fft2d_pkg::dp_cmd_t         cmd;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log2_side_q     <= fft2d_pkg::LG_W'(fft2d_pkg::MAX_LG);
      three_channel_q <= 1'b0;
    end else if (cfg_we) begin
      if (paddr[2] == fft2d_pkg::REG_LOG2_SIDE) begin
        log2_side_q <= pwdata[fft2d_pkg::LG_W-1:0];
      end else begin
        three_channel_q <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == fft2d_pkg::REG_THREE_CHANNEL) ? {31'b0, three_channel_q}
                                                            : 32'(log2_side_q);

  fft2d_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_item_i       (in_item_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .log2_side_i     (log2_side_q),
    .three_channel_i (three_channel_q),
    .cmd_o           (cmd)
  );

  fft2d_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

endmodule
`default_nettype wire
